@@ src/ttl_token_table_core_macros.svh @@
// Assertion helpers for the token table core.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef TTL_TOKEN_TABLE_CORE_MACROS_SVH
`define TTL_TOKEN_TABLE_CORE_MACROS_SVH

// Same-cycle implication.
`define TTL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TTL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ttl_pkg.sv @@
package ttl_pkg;

  // Entry layout in the table memory: {valid, key, expiry}
  localparam int KEY_W  = 32;
  localparam int EXP_W  = 33;
  localparam int WORD_W = 1 + KEY_W + EXP_W;

  localparam logic [1:0] OP_GENERATE = 2'd0;
  localparam logic [1:0] OP_RENEW    = 2'd1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_NO_KEY = 2'd2;

  localparam logic [6:0] COUNT_MAX = 7'd127;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] token_key;
    logic [31:0] now;
  } in_req_t;

  typedef struct packed {
    logic [6:0] live_count;
    logic [1:0] status;
  } out_rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

@@ src/ttl_ram.sv @@
module ttl_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one port, read the other with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/ttl_token_table_core.sv @@
// Token table with expiry: each request is scanned over every entry, then committed
// in S_DONE; the strobe follows, and the next request is taken in the strobe cycle.
// The scan reads every entry through the single read port of the table memory, one
// entry a cycle. Reset: a clearing pass writes every entry invalid, busy high
// meanwhile; configuration writes are taken during it. time_to_live resets to 1.
`include "ttl_token_table_core_macros.svh"

module ttl_token_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ttl_pkg::in_req_t  in_req,
  output logic              out_valid,
  output ttl_pkg::out_rsp_t out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  import ttl_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 8;
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  state_t state_r, state_nxt;

  logic [31:0] ttl_r;
  logic [AW-1:0] addr_r;
  logic issue_r;
  logic rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic rd_last_r;

  // Request held during the scan
  logic [1:0] op_r;
  logic [KEY_W-1:0] key_r;
  logic [31:0] now_r;
  logic [EXP_W-1:0] exp_r;
  logic ttl_nz_r;

  // Scan results
  logic hit_r;
  logic [AW-1:0] hit_idx_r;
  logic hit_live_r;
  logic free_r;
  logic [AW-1:0] free_idx_r;
  logic [CW-1:0] cnt_r;

  logic out_valid_r;
  out_rsp_t out_rsp_r;

  // Memory access
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic ram_re;
  logic [WORD_W-1:0] ram_rdata;

  // Read word fields
  logic rd_valid;
  logic [KEY_W-1:0] rd_key;
  logic [EXP_W-1:0] rd_exp;
  logic rd_match;
  logic rd_live;

  // Commit decision
  logic wr_en;
  logic [AW-1:0] wr_slot;
  logic old_live;
  logic [1:0] status_d;
  logic [CW:0] cnt_adj;
  logic [XW-1:0] cnt_x;

  logic accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  ttl_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  // Split the returned entry and test it against the request
  assign rd_valid = ram_rdata[WORD_W-1];
  assign rd_key   = ram_rdata[KEY_W+EXP_W-1:EXP_W];
  assign rd_exp   = ram_rdata[EXP_W-1:0];
  assign rd_match = rd_valid && (rd_key == key_r);
  assign rd_live  = rd_valid && (rd_exp > {1'b0, now_r});

  // Pick the slot to write and the status once the scan is complete
  always_comb begin
    wr_en    = 1'b0;
    wr_slot  = hit_idx_r;
    old_live = 1'b0;
    status_d = STAT_OK;
    case (op_r)
      OP_GENERATE: begin
        if (hit_r) begin
          wr_en    = 1'b1;
          wr_slot  = hit_idx_r;
          old_live = hit_live_r;
        end else if (free_r) begin
          wr_en    = 1'b1;
          wr_slot  = free_idx_r;
        end else begin
          status_d = STAT_FULL;
        end
      end
      OP_RENEW: begin
        if (hit_r && hit_live_r) begin
          wr_en    = 1'b1;
          wr_slot  = hit_idx_r;
          old_live = 1'b1;
        end else begin
          status_d = STAT_NO_KEY;
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
    cnt_adj = {1'b0, cnt_r} - (CW + 1)'(old_live) + (CW + 1)'(wr_en && ttl_nz_r);
    cnt_x   = XW'(cnt_adj[CW-1:0]);
  end

  // Next state and memory control
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (addr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re = issue_r;
        if (rd_vld_r && rd_last_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ram_we    = wr_en;
        ram_waddr = wr_slot;
        ram_wdata = {1'b1, key_r, exp_r};
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ttl_r       <= 32'd1;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= ram_re;
      out_valid_r <= (state_r == S_DONE);
      if (cfg_valid) begin
        ttl_r <= cfg_data;
      end
      case (state_r)
        S_CLEAR: begin
          addr_r <= (addr_r == LAST) ? '0 : addr_r + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            addr_r  <= '0;
            issue_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (issue_r) begin
            if (addr_r == LAST) begin
              issue_r <= 1'b0;
            end else begin
              addr_r <= addr_r + 1'b1;
            end
          end
        end
        default: begin
          issue_r <= 1'b0;
        end
      endcase
    end
  end

  // Latch the request, accumulate the scan, form the result
  always_ff @(posedge clk) begin
    rd_idx_r  <= addr_r;
    rd_last_r <= (addr_r == LAST);
    if (accept) begin
      op_r     <= in_req.op;
      key_r    <= in_req.token_key;
      now_r    <= in_req.now;
      exp_r    <= {1'b0, in_req.now} + {1'b0, ttl_r};
      ttl_nz_r <= (ttl_r != 32'd0);
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      cnt_r    <= '0;
    end
    if ((state_r == S_SCAN) && rd_vld_r) begin
      if (rd_match && !hit_r) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= rd_idx_r;
        hit_live_r <= rd_live;
      end
      if (!rd_live && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (rd_live) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (state_r == S_DONE) begin
      out_rsp_r.status     <= status_d;
      out_rsp_r.live_count <= (cnt_x > XW'(COUNT_MAX)) ? COUNT_MAX : cnt_x[6:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `TTL_ASSERT_NXT(a_done_strobe, state_r == S_DONE, out_valid && !busy, "no strobe after commit")
  `TTL_ASSERT_NXT(a_accept_busy, start && !busy, busy && !out_valid, "accept did not start a scan")
  `TTL_ASSERT_IMP(a_scan_no_write, state_r == S_SCAN || state_r == S_IDLE, !ram_we,
                  "table written outside clear or commit")
  `TTL_ASSERT_IMP(a_cnt_bound, state_r == S_DONE, cnt_r <= CW'(TABLE_DEPTH),
                  "live count above table depth")

endmodule
